// File: sv/gsd_pkg.sv
package gsd_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASELINE_WINDOW = 8'd0,
    CFG_AGC_WINDOW      = 8'd1,
    CFG_NOISE_MARGIN    = 8'd2,
    CFG_TIME_JUMP_LIMIT = 8'd3
  } cfg_index_t;

  // Register reset values
  localparam logic [15:0] BASELINE_WINDOW_RST = 16'd100;
  localparam logic [15:0] AGC_WINDOW_RST      = 16'd100;
  localparam logic [15:0] NOISE_MARGIN_RST    = 16'd20;
  localparam logic [31:0] TIME_JUMP_LIMIT_RST = 32'd1000;

  // Microseconds per millisecond
  localparam logic [9:0] US_PER_MS = 10'd1000;

  // Accumulator and sample counter widths
  localparam int SUM_W = 33;
  localparam int CNT_W = 17;

  // Threshold in microseconds: (limit + 1) * 1000
  localparam int THRESH_W = 43;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic div_gain;
    logic load_base;
    logic load_gain;
    logic check;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic base_close;
    logic gain_close;
    logic div_done;
  } dp_status_t;

endpackage

// File: sv/gsd_report_if.sv
interface gsd_report_if;
  logic        valid;
  logic        ready;
  logic [15:0] noise_level;
  logic [15:0] gain_level;
  logic [63:0] utc_time_us;

  modport source (output valid, noise_level, gain_level, utc_time_us, input ready);
  modport sink (input valid, noise_level, gain_level, utc_time_us, output ready);
endinterface

// File: sv/gsd_status_if.sv
interface gsd_status_if;
  logic        valid;
  logic        ready;
  logic        spoof_flag;
  logic        baseline_valid;
  logic [15:0] noise_floor;
  logic [15:0] gain_average;
  logic        time_jump_seen;

  modport source (
    output valid, spoof_flag, baseline_valid, noise_floor, gain_average, time_jump_seen,
    input  ready
  );
  modport sink (
    input  valid, spoof_flag, baseline_valid, noise_floor, gain_average, time_jump_seen,
    output ready
  );
endinterface

// File: sv/gsd_cfg_if.sv
interface gsd_cfg_if
  import gsd_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/gsd_divider.sv
module gsd_divider
  import gsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [15:0]      quotient
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  logic              active;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    rem_sub;
  logic              fits;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_shift = {rem, quo[SUM_W-1]};
    rem_sub   = rem_shift - {1'b0, divisor};
    fits      = rem_shift >= {1'b0, divisor};
  end

  // Track busy and flag completion for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && step == STEP_LAST) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  // Advance quotient and remainder, one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      step <= '0;
    end else if (active) begin
      quo  <= {quo[SUM_W-2:0], fits};
      rem  <= fits ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      step <= step + 1'b1;
    end
  end

  assign quotient = quo[15:0];

endmodule

// File: sv/gsd_datapath.sv
module gsd_datapath
  import gsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic [15:0]            noise_level,
  input  logic [15:0]            gain_level,
  input  logic [63:0]            utc_time_us,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   spoof_flag,
  output logic                   baseline_valid,
  output logic [15:0]            noise_floor,
  output logic [15:0]            gain_average,
  output logic                   time_jump_seen
);

  // Configuration
  logic [15:0]         baseline_window;
  logic [15:0]         agc_window;
  logic [15:0]         noise_margin;
  logic [31:0]         time_jump_limit;
  logic [THRESH_W-1:0] thresh;

  // Captured report
  logic [15:0] noise_r;
  logic [15:0] gain_r;
  logic [63:0] now_r;

  // Detector state
  logic [CNT_W-1:0] window_count;
  logic [SUM_W-1:0] noise_sum;
  logic [CNT_W-1:0] noise_samples;
  logic             measuring;
  logic             base_done;
  logic [15:0]      base_value;
  logic [SUM_W-1:0] gain_sum;
  logic [CNT_W-1:0] gain_samples;
  logic [15:0]      gain_mean;
  logic [63:0]      ref_time;
  logic             spoof_latched;

  // Per-report working values
  logic        base_close;
  logic        gain_close;
  logic [64:0] time_sub;
  logic [63:0] time_diff;
  logic        ref_zero;
  logic        jump;

  // Update-phase next values
  logic             meas;
  logic [SUM_W-1:0] noise_sum_next;
  logic [CNT_W-1:0] noise_samples_next;
  logic [CNT_W-1:0] window_count_next;
  logic             base_wrap;
  logic [SUM_W-1:0] gain_sum_next;
  logic [CNT_W-1:0] gain_samples_next;
  logic             gain_wrap;

  // Check-phase terms
  logic [16:0] noise_limit;
  logic        gain_hit;
  logic        jump_hit;

  // Divider
  logic             div_done;
  logic [15:0]      quotient;
  logic [SUM_W-1:0] div_dividend;
  logic [CNT_W-1:0] div_divisor;

  always_comb begin
    meas               = measuring && !base_done;
    noise_sum_next     = meas ? noise_sum + SUM_W'(noise_r) : noise_sum;
    noise_samples_next = meas ? noise_samples + 1'b1 : noise_samples;
    window_count_next  = window_count + 1'b1;
    base_wrap          = window_count_next > {1'b0, baseline_window};
    gain_sum_next      = gain_sum + SUM_W'(gain_r);
    gain_samples_next  = gain_samples + 1'b1;
    gain_wrap          = gain_samples_next > {1'b0, agc_window};
  end

  always_comb begin
    noise_limit = {1'b0, noise_margin} + {1'b0, base_value};
    gain_hit    = gain_close && base_done && ({1'b0, noise_r} > noise_limit) &&
                  (gain_r <= gain_mean);
    jump_hit    = !ref_zero && (time_diff >= 64'(thresh));
  end

  assign div_dividend = cmd.div_gain ? gain_sum : noise_sum;
  assign div_divisor  = cmd.div_gain ? gain_samples : noise_samples;

  gsd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_window <= BASELINE_WINDOW_RST;
      agc_window      <= AGC_WINDOW_RST;
      noise_margin    <= NOISE_MARGIN_RST;
      time_jump_limit <= TIME_JUMP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_BASELINE_WINDOW: baseline_window <= cfg_data[15:0];
        CFG_AGC_WINDOW:      agc_window      <= cfg_data[15:0];
        CFG_NOISE_MARGIN:    noise_margin    <= cfg_data[15:0];
        CFG_TIME_JUMP_LIMIT: time_jump_limit <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Jump threshold in microseconds; a step of (limit+1) ms or more fires
  always_ff @(posedge clk) begin
    thresh <= THRESH_W'({1'b0, time_jump_limit} + 33'd1) * THRESH_W'(US_PER_MS);
  end

  // Capture report; form absolute time difference
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      noise_r <= noise_level;
      gain_r  <= gain_level;
      now_r   <= utc_time_us;
    end
    if (cmd.update) begin
      time_sub <= {1'b0, now_r} - {1'b0, ref_time};
      ref_zero <= ref_time == 64'd0;
    end
    time_diff <= time_sub[64] ? (~time_sub[63:0] + 64'd1) : time_sub[63:0];
  end

  // Detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count  <= '0;
      noise_sum     <= '0;
      noise_samples <= '0;
      measuring     <= 1'b0;
      base_done     <= 1'b0;
      base_value    <= '0;
      gain_sum      <= '0;
      gain_samples  <= '0;
      gain_mean     <= '0;
      ref_time      <= '0;
      spoof_latched <= 1'b0;
      base_close    <= 1'b0;
      gain_close    <= 1'b0;
      jump          <= 1'b0;
    end else begin
      // Advance counters and accumulators
      if (cmd.update) begin
        noise_sum     <= noise_sum_next;
        noise_samples <= noise_samples_next;
        window_count  <= base_wrap ? '0 : window_count_next;
        base_close    <= base_wrap && meas;
        measuring     <= measuring || base_wrap;
        gain_sum      <= gain_sum_next;
        gain_samples  <= gain_samples_next;
        gain_close    <= gain_wrap;
      end
      // Fix the baseline once
      if (cmd.load_base) begin
        base_done  <= 1'b1;
        base_value <= (noise_samples == '0) ? 16'd0 : quotient;
      end
      // Close the gain window
      if (cmd.load_gain) begin
        gain_mean    <= quotient;
        gain_sum     <= '0;
        gain_samples <= '0;
      end
      // Run spoofing checks; hold the reference on a jump
      if (cmd.check) begin
        spoof_latched <= spoof_latched || gain_hit || jump_hit;
        jump          <= jump_hit;
        if (!jump_hit) begin
          ref_time <= now_r;
        end
      end
    end
  end

  // Load result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      spoof_flag     <= spoof_latched;
      baseline_valid <= base_done;
      noise_floor    <= base_value;
      gain_average   <= gain_mean;
      time_jump_seen <= jump;
    end
  end

  assign status.base_close = base_close;
  assign status.gain_close = gain_close;
  assign status.div_done   = div_done;

endmodule

// File: sv/gsd_ctrl.sv
module gsd_ctrl
  import gsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_BASE_START,
    S_BASE_WAIT,
    S_GAIN_START,
    S_GAIN_WAIT,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  // Sequence one report through the datapath
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_BASE_START;
      end
      S_BASE_START: begin
        if (status.base_close) begin
          cmd.div_start = 1'b1;
          state_next    = S_BASE_WAIT;
        end else begin
          state_next = S_GAIN_START;
        end
      end
      S_BASE_WAIT: begin
        if (status.div_done) begin
          cmd.load_base = 1'b1;
          state_next    = S_GAIN_START;
        end
      end
      S_GAIN_START: begin
        cmd.div_gain = 1'b1;
        if (status.gain_close) begin
          cmd.div_start = 1'b1;
          state_next    = S_GAIN_WAIT;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_GAIN_WAIT: begin
        cmd.div_gain = 1'b1;
        if (status.div_done) begin
          cmd.load_gain = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/gnss_spoofing_detector.sv
// Spoofing detector for a satellite navigation receiver.
// report (sink): one receiver report per transfer: noise level, AGC gain level and
//   UTC time in microseconds. Every report yields exactly one status transfer.
// status (source): sticky spoofing flag, baseline valid, noise baseline, latest
//   AGC window average and whether this report's time step exceeded the limit.
// cfg (sink): register writes by index (0 baseline window, 1 AGC window,
//   2 noise margin, 3 time jump limit in ms); always ready, other indexes drop.
//   Write only while no report is in flight.
// Processing: a report that closes no window needs no division; one that closes an
//   AGC or the baseline window needs one average, and both need two, each on the
//   shared bit-serial divider (33 steps plus the start). One report is processed
//   at a time, so the next report is accepted only once the last one's status is
//   loaded into the output register.
// A finished status waits in an output register; the next report is accepted
//   meanwhile, and that report's status holds until the register frees up.
// Reset clears all counters, sums, averages, the time reference and the flag,
//   and loads the register defaults.
module gnss_spoofing_detector
  import gsd_pkg::*;
(
  input logic         clk,
  input logic         rst,
  gsd_report_if.sink  report,
  gsd_status_if.source status,
  gsd_cfg_if.sink     cfg
);

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  // Configuration writes are always accepted and never stall
  assign cfg.ready = 1'b1;

  gsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (report.valid),
    .in_ready  (report.ready),
    .out_valid (status.valid),
    .out_ready (status.ready),
    .cmd       (cmd),
    .status    (dp_status)
  );

  gsd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (dp_status),
    .noise_level    (report.noise_level),
    .gain_level     (report.gain_level),
    .utc_time_us    (report.utc_time_us),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .spoof_flag     (status.spoof_flag),
    .baseline_valid (status.baseline_valid),
    .noise_floor    (status.noise_floor),
    .gain_average   (status.gain_average),
    .time_jump_seen (status.time_jump_seen)
  );

endmodule
